// ===== rtl/spiking_network_step_assert.svh =====
`ifndef SPIKING_NETWORK_STEP_ASSERT_SVH
`define SPIKING_NETWORK_STEP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SNS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SNS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sns_pkg.sv =====
package sns_pkg;

  localparam int CountW = 9;

  localparam logic [2:0] CmdLink   = 3'd0;
  localparam logic [2:0] CmdUnlink = 3'd1;
  localparam logic [2:0] CmdStim   = 3'd2;
  localparam logic [2:0] CmdTick   = 3'd3;
  localparam logic [2:0] CmdQuery  = 3'd4;
  localparam logic [2:0] CmdClear  = 3'd5;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StFull     = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;
  localparam logic [1:0] StBadIdx   = 2'd3;

  localparam logic RegNeuronCount = 1'b0;
  localparam logic RegThreshold   = 1'b1;

  typedef struct packed {
    logic signed [23:0] pot;
    logic signed [23:0] pend;
    logic               fired;
    logic [CountW-1:0]  count;
  } nstate_t;

  typedef struct packed {
    logic [8:0]         tgt;
    logic signed [15:0] wgt;
  } link_t;

endpackage

// ===== rtl/sns_ram.sv =====
module sns_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/spiking_network_step.sv =====
// Integrate-and-fire network engine. Each command word is processed by a small sequencer
// around one saturating adder, neuron state memory (NEURONS words) and synapse memory
// (NEURONS*MAX_LINKS words), each with one read port and one write port. After reset
// and after a clear command the neuron memory is swept to zero with the input stalled.
// Unlink scans the neuron's links in order; a tick visits each active neuron and, for
// each firing neuron, reads every synapse and adds its weight to the pending input of
// its target if that target is in use. One result word per command.
module spiking_network_step
  import sns_pkg::*;
#(
  parameter int NEURONS   = 512,
  parameter int MAX_LINKS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         command_i,
  input  logic [8:0]         neuron_i,
  input  logic [8:0]         target_i,
  input  logic signed [15:0] weight_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               fired_o,
  output logic [1:0]         status_o,
  output logic [6:0]         links_held_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int NW   = $clog2(NEURONS);
  localparam int KW   = $clog2(MAX_LINKS + 1);
  localparam int LAW  = $clog2(NEURONS * MAX_LINKS);
  localparam int CNTW = ($clog2(NEURONS + 1) > 10) ? $clog2(NEURONS + 1) : 10;

  localparam logic [3:0] SClr    = 4'd0;
  localparam logic [3:0] SIdle   = 4'd1;
  localparam logic [3:0] SRdn    = 4'd2;
  localparam logic [3:0] SChk    = 4'd3;
  localparam logic [3:0] SUlRd   = 4'd4;
  localparam logic [3:0] SUlChk  = 4'd5;
  localparam logic [3:0] STRd    = 4'd6;
  localparam logic [3:0] STEval  = 4'd7;
  localparam logic [3:0] STLRd   = 4'd8;
  localparam logic [3:0] STLDat  = 4'd9;
  localparam logic [3:0] STPadd  = 4'd10;
  localparam logic [3:0] SDone   = 4'd11;

  logic [3:0] st_q, st_d;
  logic [9:0] ncount_q;
  logic [22:0] thr_q;
  logic [2:0] cmd_q, cmd_d;
  logic [8:0] nrn_q, nrn_d, tgt_q, tgt_d, tw_q, tw_d;
  logic signed [15:0] wgt_q, wgt_d, lw_q, lw_d;
  logic post_q, post_d, clrcmd_q, clrcmd_d, found_q, found_d;
  logic [CNTW-1:0] i_q, i_d, cnt;
  logic [KW-1:0] k_q, k_d;
  logic [NW-1:0] clr_q, clr_d;
  nstate_t cur_q, cur_d;
  logic res_f_q, res_f_d;
  logic [1:0] res_s_q, res_s_d;
  logic [6:0] res_l_q, res_l_d;
  logic out_valid_q, out_valid_d, out_f_q, out_f_d;
  logic [1:0] out_s_q, out_s_d;
  logic [6:0] out_l_q, out_l_d;

  logic ns_we, ln_we;
  logic [NW-1:0] ns_waddr, ns_raddr;
  nstate_t ns_wdata, ns_rd;
  logic [LAW-1:0] ln_waddr, ln_raddr, ln_base;
  link_t ln_wdata, ln_rd;

  logic signed [23:0] sat_a, sat_b, sat_y;
  logic signed [24:0] sat_sum;
  logic vld, fire, in_acc;

  sns_ram #(.Width($bits(nstate_t)), .Depth(NEURONS)) u_nram (
    .clk_i, .we_i(ns_we), .waddr_i(ns_waddr), .wdata_i(ns_wdata),
    .raddr_i(ns_raddr), .rdata_o(ns_rd)
  );

  sns_ram #(.Width($bits(link_t)), .Depth(NEURONS * MAX_LINKS)) u_lram (
    .clk_i, .we_i(ln_we), .waddr_i(ln_waddr), .wdata_i(ln_wdata),
    .raddr_i(ln_raddr), .rdata_o(ln_rd)
  );

  // shared saturating adder
  assign sat_sum = {sat_a[23], sat_a} + {sat_b[23], sat_b};
  assign sat_y = (sat_sum[24] != sat_sum[23]) ?
                 (sat_sum[24] ? 24'sh800000 : 24'sh7FFFFF) : sat_sum[23:0];

  assign cnt = (CNTW'(ncount_q) > CNTW'(NEURONS)) ? CNTW'(NEURONS) : CNTW'(ncount_q);
  assign vld = CNTW'(nrn_q) < cnt;
  assign fire = ns_rd.pot >= $signed({1'b0, thr_q});
  assign in_stall_o = (st_q != SIdle);
  assign in_acc = in_valid_i && !in_stall_o;
  assign ln_base = (cmd_q == CmdTick) ? LAW'(LAW'(NW'(i_q)) * LAW'(MAX_LINKS))
                                      : LAW'(LAW'(NW'(nrn_q)) * LAW'(MAX_LINKS));

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegThreshold) ? {9'd0, thr_q} : {22'd0, ncount_q};

  assign out_valid_o  = out_valid_q;
  assign fired_o      = out_f_q;
  assign status_o     = out_s_q;
  assign links_held_o = out_l_q;

  always_comb begin
    st_d = st_q; cmd_d = cmd_q; nrn_d = nrn_q; tgt_d = tgt_q; wgt_d = wgt_q;
    tw_d = tw_q; lw_d = lw_q; post_d = post_q; clrcmd_d = clrcmd_q;
    found_d = found_q; i_d = i_q; k_d = k_q; clr_d = clr_q; cur_d = cur_q;
    res_f_d = res_f_q; res_s_d = res_s_q; res_l_d = res_l_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_f_d = out_f_q; out_s_d = out_s_q; out_l_d = out_l_q;
    ns_we = 1'b0; ns_waddr = NW'(nrn_q); ns_wdata = cur_q; ns_raddr = NW'(nrn_q);
    ln_we = 1'b0; ln_waddr = ln_base + LAW'(k_q); ln_raddr = ln_base + LAW'(k_q);
    ln_wdata = ln_rd;
    sat_a = ns_rd.pot; sat_b = ns_rd.pend;
    unique case (st_q)
      SClr: begin
        ns_we = 1'b1;
        ns_waddr = clr_q;
        ns_wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == NW'(NEURONS - 1)) begin
          if (clrcmd_q) begin
            res_f_d = 1'b0; res_s_d = StOk; res_l_d = '0;
            clrcmd_d = 1'b0;
            st_d = SDone;
          end else begin
            st_d = SIdle;
          end
        end
      end
      SIdle: begin
        if (in_acc) begin
          cmd_d = command_i; nrn_d = neuron_i; tgt_d = target_i; wgt_d = weight_i;
          post_d = 1'b0;
          st_d = SRdn;
        end
      end
      SRdn: st_d = SChk;
      SChk: begin
        cur_d = ns_rd;
        st_d = SDone;
        res_f_d = ns_rd.fired; res_s_d = StOk; res_l_d = 7'(ns_rd.count);
        if (post_q) begin
          if (!vld) begin
            res_f_d = 1'b0; res_l_d = '0;
          end
        end else begin
          case (cmd_q) inside
            CmdTick: begin
              i_d = '0;
              if (cnt == '0) begin
                post_d = 1'b1;
                st_d = SRdn;
              end else begin
                st_d = STRd;
              end
            end
            CmdClear: begin
              clr_d = '0;
              clrcmd_d = 1'b1;
              st_d = SClr;
            end
            CmdLink, CmdUnlink, CmdStim, CmdQuery: begin
              if (!vld) begin
                res_f_d = 1'b0; res_s_d = StBadIdx; res_l_d = '0;
              end else if (cmd_q == CmdLink) begin
                if (CNTW'(tgt_q) >= cnt) begin
                  res_s_d = StBadIdx;
                end else if (ns_rd.count >= CountW'(MAX_LINKS)) begin
                  res_s_d = StFull;
                end else begin
                  ln_we = 1'b1;
                  ln_waddr = ln_base + LAW'(ns_rd.count);
                  ln_wdata = '{tgt: tgt_q, wgt: wgt_q};
                  ns_we = 1'b1;
                  ns_wdata = ns_rd;
                  ns_wdata.count = ns_rd.count + 1'b1;
                  res_l_d = 7'(ns_rd.count + 1'b1);
                end
              end else if (cmd_q == CmdUnlink) begin
                k_d = '0;
                found_d = 1'b0;
                st_d = SUlRd;
              end else if (cmd_q == CmdStim) begin
                ns_we = 1'b1;
                ns_wdata = ns_rd;
                ns_wdata.pot = $signed({1'b0, thr_q});
              end
            end
            default: begin
              res_f_d = 1'b0; res_s_d = StBadIdx; res_l_d = '0;
            end
          endcase
        end
      end
      SUlRd: begin
        if (CountW'(k_q) == cur_q.count) begin
          res_f_d = cur_q.fired;
          st_d = SDone;
          if (found_q) begin
            ns_we = 1'b1;
            ns_wdata = cur_q;
            ns_wdata.count = cur_q.count - 1'b1;
            res_s_d = StOk;
            res_l_d = 7'(cur_q.count - 1'b1);
          end else begin
            res_s_d = StNotFound;
            res_l_d = 7'(cur_q.count);
          end
        end else begin
          st_d = SUlChk;
        end
      end
      SUlChk: begin
        // entries after the match move down by one
        if (found_q) begin
          ln_we = 1'b1;
          ln_waddr = ln_base + LAW'(k_q) - 1'b1;
        end else if (ln_rd.tgt == tgt_q) begin
          found_d = 1'b1;
        end
        k_d = k_q + 1'b1;
        st_d = SUlRd;
      end
      STRd: begin
        ns_raddr = NW'(i_q);
        st_d = STEval;
      end
      STEval: begin
        cur_d = ns_rd;
        if (fire) begin
          k_d = '0;
          st_d = STLRd;
        end else begin
          ns_we = 1'b1;
          ns_waddr = NW'(i_q);
          ns_wdata = '{pot: sat_y, pend: '0, fired: 1'b0, count: ns_rd.count};
          i_d = i_q + 1'b1;
          st_d = STRd;
          if (i_q + 1'b1 == cnt) begin
            post_d = 1'b1;
            st_d = SRdn;
          end
        end
      end
      STLRd: begin
        if (CountW'(k_q) == cur_q.count) begin
          ns_we = 1'b1;
          ns_waddr = NW'(i_q);
          ns_wdata = '{pot: '0, pend: '0, fired: 1'b1, count: cur_q.count};
          i_d = i_q + 1'b1;
          st_d = STRd;
          if (i_q + 1'b1 == cnt) begin
            post_d = 1'b1;
            st_d = SRdn;
          end
        end else begin
          st_d = STLDat;
        end
      end
      STLDat: begin
        lw_d = ln_rd.wgt;
        tw_d = ln_rd.tgt;
        if (CNTW'(ln_rd.tgt) < cnt) begin
          ns_raddr = NW'(ln_rd.tgt);
          st_d = STPadd;
        end else begin
          k_d = k_q + 1'b1;
          st_d = STLRd;
        end
      end
      STPadd: begin
        sat_a = ns_rd.pend;
        sat_b = {{8{lw_q[15]}}, lw_q};
        ns_we = 1'b1;
        ns_waddr = NW'(tw_q);
        ns_wdata = ns_rd;
        ns_wdata.pend = sat_y;
        k_d = k_q + 1'b1;
        st_d = STLRd;
      end
      SDone: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_f_d = res_f_q; out_s_d = res_s_q; out_l_d = res_l_q;
          st_d = SIdle;
        end
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= SClr;
      clr_q       <= '0;
      clrcmd_q    <= 1'b0;
      post_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      ncount_q    <= 10'd512;
      thr_q       <= 23'd30;
    end else begin
      st_q        <= st_d;
      clr_q       <= clr_d;
      clrcmd_q    <= clrcmd_d;
      post_q      <= post_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (psel && penable && pwrite) begin
        if (paddr[2] == RegNeuronCount) begin
          ncount_q <= pwdata[9:0];
        end else begin
          thr_q <= pwdata[22:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; nrn_q <= nrn_d; tgt_q <= tgt_d; wgt_q <= wgt_d;
    tw_q <= tw_d; lw_q <= lw_d; i_q <= i_d; k_q <= k_d; cur_q <= cur_d;
    res_f_q <= res_f_d; res_s_q <= res_s_d; res_l_q <= res_l_d;
    out_f_q <= out_f_d; out_s_q <= out_s_d; out_l_q <= out_l_d;
  end

endmodule

// ===== rtl/sns_checker.sv =====
`include "spiking_network_step_assert.svh"

module sns_checker
  import sns_pkg::*;
#(
  parameter int MAX_LINKS = 64
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [1:0]         status_o,
  input logic [6:0]         links_held_o
);

  `SNS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result word dropped")
  `SNS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "accepted while busy")
  `SNS_ASSERT_NOW(a_full_count, out_valid_o && status_o == StFull,
                  links_held_o == 7'(MAX_LINKS), "full table with wrong link count")
  `SNS_ASSERT_NOW(a_not_found_ok, out_valid_o && status_o == StNotFound,
                  links_held_o <= 7'(MAX_LINKS) || MAX_LINKS > 127, "link count out of range")

endmodule

bind spiking_network_step sns_checker #(.MAX_LINKS(MAX_LINKS)) u_sns_checker (.*);

// ===== verif/spiking_network_step_tb.sv =====
module spiking_network_step_tb;
  import sns_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NeuronMax = 512;
  localparam int LinkMax   = 64;
  localparam int PotHi     = 8388607;
  localparam int PotLo     = -8388608;
  localparam logic [2:0] CmdUndefA = 3'd6;
  localparam logic [2:0] CmdUndefB = 3'd7;

  typedef struct packed {
    logic       fired;
    logic [1:0] status;
    logic [6:0] links;
  } res_t;

  typedef struct {
    logic [2:0]         cmd;
    logic [8:0]         nrn;
    logic [8:0]         tgt;
    logic signed [15:0] wgt;
    bit                 typed;
    res_t               res;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         command_i = '0;
  logic [8:0]         neuron_i = '0;
  logic [8:0]         target_i = '0;
  logic signed [15:0] weight_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               fired_o;
  logic [1:0]         status_o;
  logic [6:0]         links_held_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  spiking_network_step dut (.*);

  always #5 clk_i = ~clk_i;

  // network state mirror
  int         pot [NeuronMax];
  int         pend [NeuronMax];
  bit         fired_q [NeuronMax];
  int         lcnt [NeuronMax];
  logic [8:0] ltgt [NeuronMax][LinkMax];
  int         lwgt [NeuronMax][LinkMax];
  int         ncount = 512;
  int         thresh = 30;

  res_t pending_words[$];
  int   mismatches = 0;
  bit   failed = 1'b0;
  bit   no_idle = 1'b0;
  bit   hold_long = 1'b0;

  function automatic int sat24(int v);
    if (v > PotHi) return PotHi;
    if (v < PotLo) return PotLo;
    return v;
  endfunction

  function automatic int active_neurons();
    return ncount > NeuronMax ? NeuronMax : ncount;
  endfunction

  function automatic void wipe_network();
    for (int i = 0; i < NeuronMax; i++) begin
      pot[i] = 0;
      pend[i] = 0;
      fired_q[i] = 1'b0;
      lcnt[i] = 0;
    end
  endfunction

  function automatic res_t network_step(logic [2:0] cmd, logic [8:0] n, logic [8:0] t,
                                        logic signed [15:0] w);
    int   cnt;
    bit   ok;
    bit   found;
    res_t r;
    cnt = active_neurons();
    ok = n < cnt;
    r.status = StOk;
    if (cmd == CmdTick) begin
      for (int i = 0; i < cnt; i++) begin
        if (pot[i] >= thresh) begin
          for (int k = 0; k < lcnt[i]; k++)
            if (ltgt[i][k] < cnt) pend[ltgt[i][k]] = sat24(pend[ltgt[i][k]] + lwgt[i][k]);
          pend[i] = 0;
          pot[i] = 0;
          fired_q[i] = 1'b1;
        end else begin
          fired_q[i] = 1'b0;
        end
        pot[i] = sat24(pot[i] + pend[i]);
        pend[i] = 0;
      end
    end else if (cmd == CmdClear) begin
      wipe_network();
    end else if (cmd > CmdClear) begin
      r.status = StBadIdx;
      ok = 1'b0;
    end else if (!ok) begin
      r.status = StBadIdx;
    end else if (cmd == CmdLink) begin
      if (t >= cnt) r.status = StBadIdx;
      else if (lcnt[n] >= LinkMax) r.status = StFull;
      else begin
        ltgt[n][lcnt[n]] = t;
        lwgt[n][lcnt[n]] = w;
        lcnt[n]++;
      end
    end else if (cmd == CmdUnlink) begin
      found = 1'b0;
      for (int k = 0; k < lcnt[n]; k++) begin
        if (!found && ltgt[n][k] == t) found = 1'b1;
        if (found && k + 1 < lcnt[n]) begin
          ltgt[n][k] = ltgt[n][k + 1];
          lwgt[n][k] = lwgt[n][k + 1];
        end
      end
      if (found) lcnt[n]--;
      else r.status = StNotFound;
    end else if (cmd == CmdStim) begin
      pot[n] = thresh;
    end
    r.fired = ok ? fired_q[n] : 1'b0;
    r.links = ok ? 7'(lcnt[n]) : 7'd0;
    return r;
  endfunction

  task automatic send_word(row_t rw);
    int   gap;
    res_t r;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    command_i <= rw.cmd;
    neuron_i <= rw.nrn;
    target_i <= rw.tgt;
    weight_i <= rw.wgt;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = network_step(rw.cmd, rw.nrn, rw.tgt, rw.wgt);
    pending_words.push_back(rw.typed ? rw.res : r);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == RegNeuronCount) ncount = val & 32'h3FF;
    else thresh = val & 32'h7FFFFF;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_weight();
    case ($urandom_range(0, 3))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic row_t random_row();
    row_t rw;
    int   act;
    int   sel;
    act = active_neurons();
    rw.typed = 1'b0;
    rw.res = '0;
    rw.nrn = ($urandom_range(0, 9) < 8) ? 9'($urandom_range(0, act < 511 ? act : 511))
                                         : 9'($urandom);
    rw.tgt = ($urandom_range(0, 9) < 8) ? 9'($urandom_range(0, act < 511 ? act : 511))
                                         : 9'($urandom);
    rw.wgt = pick_weight();
    sel = $urandom_range(0, 99);
    if (sel < 32) rw.cmd = CmdLink;
    else if (sel < 47) begin
      rw.cmd = CmdUnlink;
      if (rw.nrn < act && lcnt[rw.nrn] > 0 && $urandom_range(0, 3) != 0)
        rw.tgt = ltgt[rw.nrn][$urandom_range(0, lcnt[rw.nrn] - 1)];
    end
    else if (sel < 68) rw.cmd = CmdStim;
    else if (sel < 75) rw.cmd = CmdTick;
    else if (sel < 95) rw.cmd = CmdQuery;
    else if (sel < 97) rw.cmd = CmdClear;
    else rw.cmd = sel == 97 ? CmdUndefA : CmdUndefB;
    return rw;
  endfunction

  // receiver with random stalls
  initial begin
    int n;
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 9);
      if (hold_long) begin
        n = 400;
        hold_long = 1'b0;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{fired_o, status_o, links_held_o};
      if (pending_words.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", got);
      end else begin
        want = pending_words.pop_front();
        if (got !== want) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  initial begin
    #30_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    row_t dir_rows[$];
    int   phase_nc[8] = '{16, 4, 1023, 64, 0, 1, 512, 2};
    int   phase_th[8] = '{50, 1, 8388607, 100, 30, 1, 1000, 8388607};
    int   phase_len[8] = '{170, 190, 180, 170, 40, 60, 230, 180};
    dir_rows = '{
      '{CmdQuery, 9'd0, 9'd0, 16'sd0, 1'b1, '{1'b0, StOk, 7'd0}},
      '{CmdQuery, 9'd511, 9'd0, 16'sd0, 1'b1, '{1'b0, StOk, 7'd0}},
      '{CmdUndefA, 9'd0, 9'd0, 16'sd0, 1'b1, '{1'b0, StBadIdx, 7'd0}},
      '{CmdUndefB, 9'd511, 9'd511, -16'sd1, 1'b1, '{1'b0, StBadIdx, 7'd0}},
      '{CmdLink, 9'd0, 9'd1, 16'sh7FFF, 1'b1, '{1'b0, StOk, 7'd1}},
      '{CmdLink, 9'd0, 9'd511, 16'sh8000, 1'b1, '{1'b0, StOk, 7'd2}},
      '{CmdLink, 9'd0, 9'd1, 16'sd1, 1'b0, '0},
      '{CmdStim, 9'd0, 9'd0, 16'sd0, 1'b0, '0},
      '{CmdTick, 9'd0, 9'd0, 16'sd0, 1'b0, '0},
      '{CmdQuery, 9'd1, 9'd0, 16'sd0, 1'b0, '0},
      '{CmdQuery, 9'd511, 9'd0, 16'sd0, 1'b0, '0},
      '{CmdUnlink, 9'd0, 9'd5, 16'sd0, 1'b0, '0},
      '{CmdUnlink, 9'd0, 9'd1, 16'sd0, 1'b0, '0},
      '{CmdUnlink, 9'd0, 9'd1, 16'sd0, 1'b0, '0},
      '{CmdUnlink, 9'd0, 9'd511, 16'sd0, 1'b0, '0},
      '{CmdUnlink, 9'd0, 9'd511, 16'sd0, 1'b0, '0},
      '{CmdStim, 9'd1, 9'd0, 16'sd0, 1'b0, '0},
      '{CmdTick, 9'd1, 9'd0, 16'sd0, 1'b0, '0},
      '{CmdTick, 9'd1, 9'd0, 16'sd0, 1'b0, '0},
      '{CmdClear, 9'd0, 9'd0, 16'sd0, 1'b1, '{1'b0, StOk, 7'd0}},
      '{CmdQuery, 9'd1, 9'd0, 16'sd0, 1'b1, '{1'b0, StOk, 7'd0}}
    };
    wipe_network();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) send_word(dir_rows[i]);
    wait_drained();
    for (int p = 0; p < 8; p++) begin
      write_reg(RegNeuronCount, phase_nc[p]);
      write_reg(RegThreshold, phase_th[p]);
      no_idle = (p == 1 || p == 5);
      for (int i = 0; i < phase_len[p]; i++) begin
        if (p == 3 && i == 40) hold_long = 1'b1;
        if (p == 3 && i == 100) wait_drained();
        send_word(random_row());
      end
      wait_drained();
    end
    repeat (100) @(posedge clk_i);
    if (!failed && pending_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
